@@ sv/oblivious_chained_hash_join_assert.svh @@
// Assertion macros for the hash join block
`ifndef OBLIVIOUS_CHAINED_HASH_JOIN_ASSERT_SVH
`define OBLIVIOUS_CHAINED_HASH_JOIN_ASSERT_SVH
// implication checked every clock, off during reset
`define OCHJ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define OCHJ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/ochj_pkg.sv @@
// ----------------------------------------------------------------------------
// ochj_pkg
// Shared types and constants of the hash join block.
// ----------------------------------------------------------------------------
package ochj_pkg;
    localparam int DEF_BUILD_CAPACITY = 64;
    localparam int HEAD_DEPTH = 64;
    localparam int HEAD_AW = 6;
    localparam int CNT_W = 7;
    localparam int SHIFT_W = 5;
    localparam int KEY_W = 32;

    localparam logic [1:0] REQ_BUILD = 2'd0;
    localparam logic [1:0] REQ_PROBE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic CFG_BUILD_COUNT = 1'b0;
    localparam logic CFG_RADIX_SHIFT = 1'b1;

    // classified request from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] payload;
        logic [HEAD_AW-1:0] bucket;
    } cmd_t;
endpackage

@@ sv/ochj_ram.sv @@
// ----------------------------------------------------------------------------
// ochj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ochj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

@@ sv/ochj_front.sv @@
// ----------------------------------------------------------------------------
// ochj_front
// Accepts requests, computes the bucket and queues them for the back end.
// ----------------------------------------------------------------------------
module ochj_front
    import ochj_pkg::*;
#(
    parameter int BUILD_CAPACITY = DEF_BUILD_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic [KEY_W-1:0]   key,
    input  logic [KEY_W-1:0]   payload,
    input  logic [CNT_W-1:0]   build_count,
    input  logic [SHIFT_W-1:0] radix_shift,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_take
);
    localparam int QD = 2;
    cmd_t q_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [CNT_W-1:0] eff;
    logic [HEAD_AW-1:0] mask;
    logic [KEY_W-1:0] shifted;
    cmd_t c;
    logic acc;

    always_comb
    begin
        eff = (build_count > CNT_W'(BUILD_CAPACITY)) ? CNT_W'(BUILD_CAPACITY) : build_count;
        mask = '0;
        for (int i = 0; i < HEAD_AW; i++)
        begin
            // bit i set when 2^i < eff, giving next-pow2 minus one
            if ((CNT_W'(1) << i) < eff)
            begin
                mask[i] = 1'b1;
            end
        end
        shifted = key >> radix_shift;
        c.op = req_type;
        c.key = key;
        c.payload = payload;
        c.bucket = shifted[HEAD_AW-1:0] & mask;
    end

    assign full = (cnt_reg == 2'(QD));
    assign acc = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (cmd_take && cmd_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(acc) - 2'(cmd_take && cmd_valid);
        end
    end
endmodule

@@ sv/ochj_back.sv @@
// ----------------------------------------------------------------------------
// ochj_back
// Executes builds, probes and clears against the chained table; one output register.
// ----------------------------------------------------------------------------
module ochj_back
    import ochj_pkg::*;
#(
    parameter int BUILD_CAPACITY = DEF_BUILD_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   build_count,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output logic               is_match,
    output logic [KEY_W-1:0]   match_key,
    output logic [KEY_W-1:0]   build_payload,
    output logic [KEY_W-1:0]   probe_payload,
    output logic [KEY_W-1:0]   out_slot,
    output logic               last
);
    `include "oblivious_chained_hash_join_assert.svh"

    localparam int EAW = $clog2(BUILD_CAPACITY);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0] st_reg;
    logic [HEAD_DEPTH-1:0] hvld_reg;
    logic [CNT_W-1:0] built_reg;
    logic [KEY_W-1:0] slot_reg;
    logic [1:0] op_reg;
    logic [HEAD_AW-1:0] bkt_reg;
    logic [KEY_W-1:0] pkey_reg, ppay_reg;
    logic [CNT_W-1:0] hit_reg;
    logic [CNT_W-1:0] eff;

    logic ov_reg;
    logic o_match_reg, o_last_reg;
    logic [KEY_W-1:0] o_key_reg, o_bpay_reg, o_ppay_reg, o_slot_reg;

    logic wr_build;
    logic [CNT_W-1:0] head_rd, head_val, new_head, hop_next;
    logic [EAW-1:0] waddr, raddr;
    logic [CNT_W-1:0] link_rd;
    logic [KEY_W-1:0] key_rd, pay_rd;
    logic build_ok;
    logic out_free;
    logic row_hit;

    assign eff = (build_count > CNT_W'(BUILD_CAPACITY)) ? CNT_W'(BUILD_CAPACITY) : build_count;
    assign build_ok = (built_reg < eff);
    assign out_free = !ov_reg || pop;
    assign cmd_take = (st_reg == ST_IDLE) && cmd_valid;
    // a bucket without its valid bit is empty since the last clear
    assign head_val = hvld_reg[bkt_reg] ? head_rd : '0;
    assign new_head = built_reg + 1'b1;
    assign wr_build = (st_reg == ST_HEAD) && (op_reg == REQ_BUILD);
    assign waddr = built_reg[EAW-1:0];
    assign row_hit = (key_rd == pkey_reg);

    // hop being read; a stalled walk keeps re-reading the same entry
    always_comb
    begin
        case (st_reg)
            ST_HEAD: hop_next = head_val;
            ST_WALK: hop_next = out_free ? link_rd : hit_reg;
            default: hop_next = hit_reg;
        endcase
    end
    assign raddr = EAW'(hop_next - 1'b1);

    ochj_ram #(.WIDTH(CNT_W), .DEPTH(HEAD_DEPTH)) u_head (
        .clk(clk), .we(wr_build), .waddr(bkt_reg), .wdata(new_head), .raddr(cmd.bucket),
        .rdata(head_rd));
    ochj_ram #(.WIDTH(CNT_W), .DEPTH(BUILD_CAPACITY)) u_link (
        .clk(clk), .we(wr_build), .waddr(waddr), .wdata(head_val), .raddr(raddr),
        .rdata(link_rd));
    ochj_ram #(.WIDTH(KEY_W), .DEPTH(BUILD_CAPACITY)) u_key (
        .clk(clk), .we(wr_build), .waddr(waddr), .wdata(pkey_reg), .raddr(raddr),
        .rdata(key_rd));
    ochj_ram #(.WIDTH(KEY_W), .DEPTH(BUILD_CAPACITY)) u_pay (
        .clk(clk), .we(wr_build), .waddr(waddr), .wdata(ppay_reg), .raddr(raddr),
        .rdata(pay_rd));

    assign empty = !ov_reg;
    assign is_match = o_match_reg;
    assign match_key = o_key_reg;
    assign build_payload = o_bpay_reg;
    assign probe_payload = o_ppay_reg;
    assign out_slot = o_slot_reg;
    assign last = o_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg <= cmd.op;
            bkt_reg <= cmd.bucket;
            pkey_reg <= cmd.key;
            ppay_reg <= cmd.payload;
        end
        if (st_reg == ST_WALK && out_free)
        begin
            o_match_reg <= row_hit;
            o_key_reg <= row_hit ? pkey_reg : '0;
            o_bpay_reg <= row_hit ? pay_rd : '0;
            o_ppay_reg <= row_hit ? ppay_reg : '0;
            o_slot_reg <= slot_reg;
            o_last_reg <= (link_rd == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            hvld_reg <= '0;
            built_reg <= '0;
            slot_reg <= '0;
            hit_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == ST_WALK && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop && ov_reg)
            begin
                ov_reg <= 1'b0;
            end
            if (st_reg != ST_IDLE)
            begin
                hit_reg <= hop_next;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (cmd.op == REQ_CLEAR)
                        begin
                            built_reg <= '0;
                            hvld_reg <= '0;
                        end
                        else if ((cmd.op == REQ_BUILD && build_ok) || cmd.op == REQ_PROBE)
                        begin
                            st_reg <= ST_HEAD;
                        end
                    end
                end
                ST_HEAD:
                begin
                    // head read done: link the build in, start the walk, or end a probe on an empty bucket
                    if (op_reg == REQ_BUILD)
                    begin
                        hvld_reg[bkt_reg] <= 1'b1;
                        built_reg <= new_head;
                        st_reg <= ST_IDLE;
                    end
                    else if (head_val != '0)
                    begin
                        st_reg <= ST_WALK;
                    end
                    else
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_WALK:
                begin
                    if (out_free)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        if (link_rd == '0)
                        begin
                            st_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `OCHJ_ASSERT_IMP(a_build_bound, 1'b1, built_reg <= CNT_W'(BUILD_CAPACITY))
    `OCHJ_ASSERT_IMP(a_walk_nonzero, st_reg == ST_WALK, hit_reg != '0)
    `OCHJ_ASSERT_NXT(a_slot_step, st_reg == ST_WALK && out_free,
        ov_reg && o_slot_reg == slot_reg - 1'b1)
endmodule

@@ sv/oblivious_chained_hash_join.sv @@
// ----------------------------------------------------------------------------
// oblivious_chained_hash_join
// Bucket-chaining hash join emitting real and dummy rows.
// ----------------------------------------------------------------------------
// A build reads the bucket head in the back end, then does the table writes;
// clears, dropped builds and unused requests finish in the idle state. A probe
// reads the bucket head, then walks the chain one element per cycle while rows
// are popped on time; a row waiting in the output register holds the walk. A
// two-entry request queue lets new requests in while a probe is walking. Bucket
// heads sit in a RAM with a valid bit per bucket, so reset and clear zero only the valid bits.
module oblivious_chained_hash_join
    import ochj_pkg::*;
#(
    parameter int BUILD_CAPACITY = DEF_BUILD_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         req_type,
    input  logic [KEY_W-1:0]   key,
    input  logic [KEY_W-1:0]   payload,
    output logic               empty,
    input  logic               pop,
    output logic               is_match,
    output logic [KEY_W-1:0]   match_key,
    output logic [KEY_W-1:0]   build_payload,
    output logic [KEY_W-1:0]   probe_payload,
    output logic [KEY_W-1:0]   out_slot,
    output logic               last,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_data
);
    logic [CNT_W-1:0] build_count_reg;
    logic [SHIFT_W-1:0] radix_shift_reg;
    logic cmd_valid, cmd_take;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            build_count_reg <= '0;
            radix_shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUILD_COUNT: build_count_reg <= cfg_data;
                CFG_RADIX_SHIFT: radix_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    ochj_front #(.BUILD_CAPACITY(BUILD_CAPACITY)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_type(req_type),
        .key(key), .payload(payload), .build_count(build_count_reg),
        .radix_shift(radix_shift_reg), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take));

    ochj_back #(.BUILD_CAPACITY(BUILD_CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .build_count(build_count_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take), .empty(empty),
        .pop(pop), .is_match(is_match), .match_key(match_key),
        .build_payload(build_payload), .probe_payload(probe_payload),
        .out_slot(out_slot), .last(last));
endmodule
